>>> hdl/sere_pkg.sv
`timescale 1ns / 1ps

package sere_pkg;

	localparam int PORT_W     = 8;
	localparam int TIME_W     = 32;
	localparam int PULSE_W    = 16;
	localparam int DIST_W     = 14;
	localparam int COUNT_W    = 8;
	localparam int ECHO_SEL_W = 3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// distance = floor(width * 343 / 2000) taken as floor(width * SCALE_MULT / 2^SCALE_SHIFT).
	// The rounding error stays below 1/2000 for every 16-bit width, so the quotient is exact.
	localparam int SCALE_SHIFT  = 27;
	localparam int SCALE_MULT_W = 25;
	localparam logic [SCALE_MULT_W-1:0] SCALE_MULT = 25'd23018341;
	localparam int PROD_W = PULSE_W + SCALE_MULT_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ECHO_BIT       = 3'd0,
		REG_MIN_PULSE      = 3'd1,
		REG_MAX_PULSE      = 3'd2,
		REG_DETECT         = 3'd3,
		REG_DEBOUNCE_LIMIT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [ECHO_SEL_W-1:0] echo_bit;
		logic [PULSE_W-1:0]    min_pulse_us;
		logic [PULSE_W-1:0]    max_pulse_us;
		logic [DIST_W-1:0]     detect_mm;
		logic [COUNT_W-1:0]    debounce_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		echo_bit:       3'd0,
		min_pulse_us:   16'd150,
		max_pulse_us:   16'd30000,
		detect_mm:      14'd500,
		debounce_limit: 8'd3
	};

	typedef struct packed {
		logic               meas;
		logic [PULSE_W-1:0] width;
	} pulse_t;

	typedef struct packed {
		logic              meas;
		logic [DIST_W-1:0] dist_mm;
	} range_t;

endpackage

>>> hdl/sere_if.sv
`timescale 1ns / 1ps

interface sere_in_if;
	import sere_pkg::*;

	logic              valid;
	logic              ready;
	logic [PORT_W-1:0] port_sample;
	logic [TIME_W-1:0] now_us;

	modport source(output valid, port_sample, now_us, input ready);
	modport sink(input valid, port_sample, now_us, output ready);
endinterface

interface sere_out_if;
	import sere_pkg::*;

	logic               valid;
	logic               ready;
	logic [DIST_W-1:0]  distance_mm;
	logic               measured;
	logic [COUNT_W-1:0] confirm_count;
	logic               object_confirmed;

	modport source(output valid, distance_mm, measured, confirm_count, object_confirmed,
		input ready);
	modport sink(input valid, distance_mm, measured, confirm_count, object_confirmed,
		output ready);
endinterface

>>> hdl/sere_pulse.sv
`timescale 1ns / 1ps

module sere_pulse (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sere_pkg::cfg_t          cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [sere_pkg::PORT_W-1:0] port_sample,
	input  logic [sere_pkg::TIME_W-1:0] now_us,
	output logic                    valid_s1,
	input  logic                    ready_next,
	output sere_pkg::pulse_t        pulse_s1
);
	import sere_pkg::*;

	logic              echo_prev_q;
	logic [TIME_W-1:0] start_q;
	logic              echo;
	logic              accept;
	logic [TIME_W-1:0] width;
	logic              in_limits;

	assign in_ready = !valid_s1 || ready_next;
	assign accept   = in_valid && in_ready;
	assign echo     = port_sample[cfg.echo_bit];

	// Modular subtraction copes with the timestamp wrapping mid-pulse.
	assign width     = now_us - start_q;
	assign in_limits = (width >= {{(TIME_W-PULSE_W){1'b0}}, cfg.min_pulse_us}) &&
		(width <= {{(TIME_W-PULSE_W){1'b0}}, cfg.max_pulse_us});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q <= 1'b0;
			start_q     <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (accept) begin
				echo_prev_q <= echo;
				if (echo && !echo_prev_q)
					start_q <= now_us;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pulse_s1.meas  <= !echo && echo_prev_q && in_limits;
			pulse_s1.width <= width[PULSE_W-1:0];
		end
	end

endmodule

>>> hdl/sere_scale.sv
`timescale 1ns / 1ps

module sere_scale (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	output logic             ready_s1,
	input  sere_pkg::pulse_t pulse_s1,
	output logic             valid_s2,
	input  logic             ready_next,
	output sere_pkg::range_t range_s2
);
	import sere_pkg::*;

	logic [PROD_W-1:0] prod;

	assign ready_s1 = !valid_s2 || ready_next;
	assign prod = PROD_W'(pulse_s1.width) * PROD_W'(SCALE_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s1) begin
			range_s2.meas    <= pulse_s1.meas;
			range_s2.dist_mm <= prod[SCALE_SHIFT +: DIST_W];
		end
	end

endmodule

>>> hdl/sere_count.sv
`timescale 1ns / 1ps

module sere_count (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sere_pkg::cfg_t               cfg,
	input  logic                         valid_s2,
	output logic                         ready_s2,
	input  sere_pkg::range_t             range_s2,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [sere_pkg::DIST_W-1:0]  distance_mm,
	output logic                         measured,
	output logic [sere_pkg::COUNT_W-1:0] confirm_count,
	output logic                         object_confirmed
);
	import sere_pkg::*;

	logic [DIST_W-1:0]  last_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic               advance;

	assign ready_s2 = !out_valid || out_ready;
	assign advance  = valid_s2 && ready_s2;

	// The stored distance and count only move when a beat enters the result register,
	// so while a result waits they still show exactly what it reported.
	assign distance_mm   = last_q;
	assign confirm_count = count_q;

	always_comb begin
		count_d = count_q;
		if (range_s2.meas) begin
			if (range_s2.dist_mm < cfg.detect_mm) begin
				if (count_q < cfg.debounce_limit)
					count_d = count_q + COUNT_W'(1);
			end else begin
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			last_q    <= '0;
			count_q   <= '0;
		end else begin
			if (ready_s2)
				out_valid <= valid_s2;
			if (advance) begin
				count_q <= count_d;
				if (range_s2.meas)
					last_q <= range_s2.dist_mm;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			measured         <= range_s2.meas;
			object_confirmed <= (count_d >= cfg.debounce_limit);
		end
	end

endmodule

>>> hdl/sonar_echo_range_debounce.sv
`timescale 1ns / 1ps
// Echo pulse ranging with a near-object confirm counter.
// Pipeline: three register stages (pulse, scale, count); a sample beat's result moves through
// each in turn, and back-pressure from the results port can hold it in any stage.
// Throughput: one sample per cycle unless results stall; each of the three stages holds one
// beat and the single 16 x 25 bit constant multiply in the middle stage sets the clock period.
// Reset (asynchronous, active low) restores the register defaults and clears echo state.
module sonar_echo_range_debounce (
	input  logic                            clk,
	input  logic                            arst_n,
	sere_in_if.sink                         samples,
	sere_out_if.source                      results,
	input  logic                            cfg_we,
	input  logic [sere_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sere_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sere_pkg::*;

	cfg_t   cfg_q;
	logic   valid_s1;
	logic   ready_s1;
	pulse_t pulse_s1;
	logic   valid_s2;
	logic   ready_s2;
	range_t range_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ECHO_BIT:       cfg_q.echo_bit       <= cfg_wdata[ECHO_SEL_W-1:0];
				REG_MIN_PULSE:      cfg_q.min_pulse_us   <= cfg_wdata[PULSE_W-1:0];
				REG_MAX_PULSE:      cfg_q.max_pulse_us   <= cfg_wdata[PULSE_W-1:0];
				REG_DETECT:         cfg_q.detect_mm      <= cfg_wdata[DIST_W-1:0];
				REG_DEBOUNCE_LIMIT: cfg_q.debounce_limit <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	sere_pulse u_pulse (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (samples.valid),
		.in_ready    (samples.ready),
		.port_sample (samples.port_sample),
		.now_us      (samples.now_us),
		.valid_s1    (valid_s1),
		.ready_next  (ready_s1),
		.pulse_s1    (pulse_s1)
	);

	sere_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.ready_s1   (ready_s1),
		.pulse_s1   (pulse_s1),
		.valid_s2   (valid_s2),
		.ready_next (ready_s2),
		.range_s2   (range_s2)
	);

	sere_count u_count (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.valid_s2         (valid_s2),
		.ready_s2         (ready_s2),
		.range_s2         (range_s2),
		.out_valid        (results.valid),
		.out_ready        (results.ready),
		.distance_mm      (results.distance_mm),
		.measured         (results.measured),
		.confirm_count    (results.confirm_count),
		.object_confirmed (results.object_confirmed)
	);

	// The confirm count either clears or steps up by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(results.confirm_count != $past(results.confirm_count)) |->
		((results.confirm_count == '0) ||
		(results.confirm_count == $past(results.confirm_count) + COUNT_W'(1))))
		else $error("confirm count moved by more than one step");

	// The stored distance changes only when a measured beat entered the result register.
	a_dist_update: assert property (@(posedge clk) disable iff (!arst_n)
		(results.distance_mm != $past(results.distance_mm)) |->
		$past(valid_s2 && ready_s2 && range_s2.meas))
		else $error("distance changed without a measured beat");

	// A measured result always carries a distance within the sensor range.
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.measured) |-> (results.distance_mm <= DIST_W'(11240)))
		else $error("measured distance out of range");

endmodule
